/* design/ppdv_pkg.sv */
`default_nettype none

package ppdv_pkg;

  localparam int unsigned FingerW = 3;
  localparam int unsigned RawW    = 12;
  localparam int unsigned CalW    = 13;
  localparam int unsigned OffW    = 12;
  localparam int unsigned VelW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 12;

  // divider: partial remainder holds (raw - baseline) * 126 plus one guard bit
  localparam int unsigned RemW    = RawW + VelW + 1;
  localparam int unsigned CntW    = 3;

  localparam logic [VelW-1:0] VelMax   = 7'd127;
  localparam logic [VelW-1:0] VelScale = 7'd126;

  localparam logic [OffW-1:0] PressOffRst   = 12'd45;
  localparam logic [OffW-1:0] ReleaseOffRst = 12'd25;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdLoad   = 1'b1;

  localparam logic KindRelease = 1'b0;
  localparam logic KindPress   = 1'b1;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgW-1:0]    cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_OFFSET   = 2'd0,
    CFG_RELEASE_OFFSET = 2'd1,
    CFG_HAND_ID        = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } ppdv_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic check;
    logic div_step;
    logic emit;
  } ppdv_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_emit;
    logic ovf;
    logic div_last;
    logic out_free;
  } ppdv_sts_t;

endpackage

`default_nettype wire

/* design/ppdv_in_if.sv */
`default_nettype none

interface ppdv_in_if;
  import ppdv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [FingerW-1:0]     finger;
  logic [RawW-1:0]        raw;
  logic [CalW-1:0]        baseline_in;
  logic [CalW-1:0]        full_in;

  modport source (
    output valid, command, finger, raw, baseline_in, full_in,
    input  ready
  );

  modport sink (
    input  valid, command, finger, raw, baseline_in, full_in,
    output ready
  );

endinterface

`default_nettype wire

/* design/ppdv_out_if.sv */
`default_nettype none

interface ppdv_out_if;
  import ppdv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   hand;
  logic [FingerW-1:0]     finger_out;
  logic                   event_kind;
  logic [VelW-1:0]        velocity;

  modport source (
    output valid, hand, finger_out, event_kind, velocity,
    input  ready
  );

  modport sink (
    input  valid, hand, finger_out, event_kind, velocity,
    output ready
  );

endinterface

`default_nettype wire

/* design/ppdv_ctrl.sv */
`default_nettype none

module ppdv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppdv_pkg::ppdv_sts_t sts_i,
  output ppdv_pkg::ppdv_cmd_t cmd_o
);
  import ppdv_pkg::*;

  ppdv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.need_div) begin
          state_d = ST_CHECK;
        end else if (sts_i.need_emit) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_d = sts_i.ovf ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval     = 1'b1;
      ST_CHECK: cmd_o.check    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_EMIT:  cmd_o.emit     = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ppdv_dp.sv */
`default_nettype none

module ppdv_dp #(
  parameter int unsigned NUM_FINGERS = 5,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  ppdv_pkg::cfg_idx_t            cfg_idx_i,
  input  ppdv_pkg::cfg_data_t           cfg_data_i,
  // input word
  input  logic                          command_i,
  input  logic [ppdv_pkg::FingerW-1:0]  finger_i,
  input  logic [ppdv_pkg::RawW-1:0]     raw_i,
  input  logic [ppdv_pkg::CalW-1:0]     baseline_in_i,
  input  logic [ppdv_pkg::CalW-1:0]     full_in_i,
  // control
  input  ppdv_pkg::ppdv_cmd_t           cmd_i,
  output ppdv_pkg::ppdv_sts_t           sts_o,
  // output word
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hand_o,
  output logic [ppdv_pkg::FingerW-1:0]  finger_out_o,
  output logic                          event_kind_o,
  output logic [ppdv_pkg::VelW-1:0]     velocity_o
);
  import ppdv_pkg::*;

  localparam int unsigned SW   = (SAMPLE_BITS < RawW) ? SAMPLE_BITS : RawW;
  localparam int unsigned IdxW = (NUM_FINGERS > 1) ? $clog2(NUM_FINGERS) : 1;
  localparam int unsigned XW   = (IdxW > FingerW) ? IdxW : FingerW;
  localparam int unsigned CmpW = CalW + 1;

  // configuration registers
  logic [OffW-1:0] poff_q, roff_q;
  logic            hand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poff_q <= PressOffRst;
      roff_q <= ReleaseOffRst;
      hand_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PRESS_OFFSET)   poff_q <= cfg_data_i[OffW-1:0];
      if (cfg_idx_i == CFG_RELEASE_OFFSET) roff_q <= cfg_data_i[OffW-1:0];
      if (cfg_idx_i == CFG_HAND_ID)        hand_q <= cfg_data_i[0];
    end
  end

  // captured word
  logic               cmd_q;
  logic [FingerW-1:0] fing_q;
  logic [SW-1:0]      raw_q;
  logic [CalW-1:0]    bin_q, fin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      fing_q <= finger_i;
      raw_q  <= raw_i[SW-1:0];
      bin_q  <= baseline_in_i;
      fin_q  <= full_in_i;
    end
  end

  // per-finger state
  logic [NUM_FINGERS-1:0] flag_q;
  logic [CalW-1:0]        base_q [NUM_FINGERS];
  logic [CalW-1:0]        full_q [NUM_FINGERS];

  logic [XW-1:0]   fing_x;
  logic [IdxW-1:0] idx;
  logic            in_range;
  logic [CalW-1:0] base_r, full_r, span;
  logic            flag_r;
  logic            press_hit, rel_hit, load_ok;
  logic [CalW-1:0] diff_full;
  logic [RawW-1:0] diff;
  logic [RemW-1:0] prod;

  always_comb begin
    fing_x    = XW'(fing_q);
    idx       = fing_x[IdxW-1:0];
    in_range  = 32'(fing_q) < NUM_FINGERS;
    base_r    = base_q[idx];
    full_r    = full_q[idx];
    flag_r    = flag_q[idx];
    press_hit = CmpW'(raw_q) >= CmpW'(base_r) + CmpW'(poff_q);
    rel_hit   = CmpW'(raw_q) <= CmpW'(base_r) + CmpW'(roff_q);
    load_ok   = bin_q < fin_q;
    // a press implies raw >= baseline, so the difference is non-negative and fits in RawW bits
    diff_full = CalW'(raw_q) - base_r;
    diff      = diff_full[RawW-1:0];
    prod      = RemW'(diff) * RemW'(VelScale);
    // loads keep baseline below full, so the span never goes negative
    span      = full_r - base_r;
  end

  assign sts_o.need_div  = in_range && (cmd_q == CmdSample) && !flag_r && press_hit;
  assign sts_o.need_emit = in_range && (cmd_q == CmdSample) && flag_r && rel_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      base_q <= '{default: '0};
      full_q <= '{default: '0};
    end else if (cmd_i.eval) begin
      if (in_range && (cmd_q == CmdLoad) && load_ok) begin
        base_q[idx] <= bin_q;
        full_q[idx] <= fin_q;
      end
      if (sts_o.need_div || sts_o.need_emit) begin
        flag_q[idx] <= sts_o.need_div;
      end
    end
  end

  // restoring divider, one quotient bit per cycle; quotients of 127 and up saturate
  logic [RemW-1:0] rem_q, sh_q, div_top;
  logic [CalW-1:0] span_q;
  logic [VelW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            ovf_q, kind_q;
  logic            fits;

  assign div_top = RemW'({span_q, 7'd0});
  assign fits    = rem_q >= sh_q;

  assign sts_o.ovf      = rem_q >= div_top;
  assign sts_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      rem_q  <= prod;
      span_q <= span;
      sh_q   <= RemW'({span, 6'd0});
      quo_q  <= '0;
      cnt_q  <= CntW'(VelW - 1);
      ovf_q  <= 1'b0;
      kind_q <= sts_o.need_div ? KindPress : KindRelease;
    end else if (cmd_i.check) begin
      ovf_q <= sts_o.ovf;
    end else if (cmd_i.div_step) begin
      if (fits) rem_q <= rem_q - sh_q;
      quo_q <= {quo_q[VelW-2:0], fits};
      sh_q  <= sh_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  logic [VelW-1:0] vel;

  always_comb begin
    if (kind_q == KindRelease) begin
      vel = '0;
    end else if (ovf_q || (quo_q == VelMax)) begin
      vel = VelMax;
    end else begin
      vel = quo_q + 1'b1;
    end
  end

  // output register
  logic               out_valid_q;
  logic               out_hand_q, out_kind_q;
  logic [FingerW-1:0] out_fing_q;
  logic [VelW-1:0]    out_vel_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hand_q <= hand_q;
      out_fing_q <= fing_q;
      out_kind_q <= kind_q;
      out_vel_q  <= vel;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hand_o       = out_hand_q;
  assign finger_out_o = out_fing_q;
  assign event_kind_o = out_kind_q;
  assign velocity_o   = out_vel_q;

endmodule

`default_nettype wire

/* design/pressure_press_detect_velocity.sv */
// Per-finger press detector with hysteresis and press velocity.
// Input channel in_i carries sample and calibration-load words; output channel
// out_o carries press/release events (hand, finger, kind, velocity). Both use
// valid/ready; a word moves when both are high.
// cfg_we_i/cfg_idx_i/cfg_data_i write press offset, release offset and hand id
// (index 0..2); write only while the block is idle. Index 3 is ignored.
// One word is handled at a time. in_i.ready is high only while idle.
// Load words and samples without an event pass IDLE and EVAL only; a release
// event then goes to EMIT, which writes the output register, a press event to
// CHECK, DIV and EMIT: its velocity comes from a restoring divider yielding one
// quotient bit per cycle over 7 steps, after a multiply and a saturation check.
// The finished event sits in an output register, so the next word is taken
// while it waits; a stalled receiver holds the block only when a second event
// is ready to be written.
// Reset clears all press flags and calibration to zero and loads the offsets
// with 45 and 25 and the hand id with 0.
`default_nettype none

module pressure_press_detect_velocity #(
  parameter int unsigned NUM_FINGERS = 5,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ppdv_pkg::cfg_idx_t  cfg_idx_i,
  input  ppdv_pkg::cfg_data_t cfg_data_i,
  ppdv_in_if.sink             in_i,
  ppdv_out_if.source          out_o
);
  import ppdv_pkg::*;

  ppdv_cmd_t cmd;
  ppdv_sts_t sts;

  ppdv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppdv_dp #(
    .NUM_FINGERS (NUM_FINGERS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (in_i.command),
    .finger_i      (in_i.finger),
    .raw_i         (in_i.raw),
    .baseline_in_i (in_i.baseline_in),
    .full_in_i     (in_i.full_in),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .hand_o        (out_o.hand),
    .finger_out_o  (out_o.finger_out),
    .event_kind_o  (out_o.event_kind),
    .velocity_o    (out_o.velocity)
  );

`ifndef SYNTHESIS
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("event written over a pending one");

  a_release_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_kind == KindRelease) |-> (out_o.velocity == '0))
    else $error("release event with nonzero velocity");
`endif

endmodule

`default_nettype wire

/* tb/pressure_press_detect_velocity_tb.sv */
module pressure_press_detect_velocity_tb;
  import ppdv_pkg::*;

  localparam int NumFingers   = 5;
  localparam int ClkHalf      = 5;
  localparam int ResetCycles  = 5;
  localparam int SettleCycles = 20;
  localparam int TimeoutUnits = 5_000_000;
  localparam int RandomWords  = 760;
  localparam int HoldCycles   = 300;

  // index 3 has no register behind it
  localparam cfg_idx_t     CfgIdxSpare = 2'd3;
  localparam logic [15:0]  RxPattern   = 16'b1011_0011_1110_0101;

  typedef struct {
    logic               cmd;
    logic [FingerW-1:0] finger;
    logic [RawW-1:0]    raw;
    logic [CalW-1:0]    base;
    logic [CalW-1:0]    full;
  } sensor_word_t;

  typedef struct {
    logic               hand;
    logic [FingerW-1:0] finger;
    logic               kind;
    logic [VelW-1:0]    velocity;
  } press_event_t;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM, RX_SLOW} rx_mode_e;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  ppdv_in_if  in_ch ();
  ppdv_out_if out_ch ();

  pressure_press_detect_velocity dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predicted block state
  logic            finger_pressed [NumFingers];
  logic [CalW-1:0] finger_base    [NumFingers];
  logic [CalW-1:0] finger_full    [NumFingers];
  logic [OffW-1:0] press_off;
  logic [OffW-1:0] release_off;
  logic            hand_sel;

  press_event_t expected_events [$];

  int       errors;
  int       words_sent;
  int       random_words;
  int       events_seen;
  int       presses_seen;
  int       cfg_writes;
  rx_mode_e rx_mode;
  int       rx_hold_left;
  int       rx_phase;
  int       burst_left;
  bit       sender_bursty;

  initial clk = 1'b0;
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  function automatic logic [VelW-1:0] press_velocity(int raw_v, int base_v, int full_v);
    int span;
    int v;
    span = full_v - base_v;
    if (span <= 0) return VelMax;
    v = (raw_v - base_v) * int'(VelScale) / span + 1;
    if (v > int'(VelMax)) v = int'(VelMax);
    if (v < 0) v = 0;
    return v[VelW-1:0];
  endfunction

  function automatic void predict_event(sensor_word_t w);
    int           f;
    int           raw_v;
    int           base_v;
    logic         now;
    press_event_t ev;
    f = w.finger;
    if (f >= NumFingers) return;
    if (w.cmd == CmdLoad) begin
      if (w.base < w.full) begin
        finger_base[f] = w.base;
        finger_full[f] = w.full;
      end
      return;
    end
    raw_v  = w.raw;
    base_v = finger_base[f];
    now    = finger_pressed[f];
    if (!now && raw_v >= base_v + int'(press_off)) now = 1'b1;
    else if (now && raw_v <= base_v + int'(release_off)) now = 1'b0;
    if (now == finger_pressed[f]) return;
    finger_pressed[f] = now;
    ev.hand     = hand_sel;
    ev.finger   = w.finger;
    ev.kind     = now ? KindPress : KindRelease;
    ev.velocity = now ? press_velocity(raw_v, base_v, finger_full[f]) : '0;
    expected_events.push_back(ev);
  endfunction

  function automatic sensor_word_t sample_word(int f, int raw_v);
    sensor_word_t w;
    w.cmd    = CmdSample;
    w.finger = f;
    w.raw    = raw_v;
    w.base   = $urandom;
    w.full   = $urandom;
    return w;
  endfunction

  function automatic sensor_word_t load_word(int f, int base_v, int full_v);
    sensor_word_t w;
    w.cmd    = CmdLoad;
    w.finger = f;
    w.raw    = $urandom;
    w.base   = base_v;
    w.full   = full_v;
    return w;
  endfunction

  // mostly calibrations and samples near the thresholds, some pure noise
  function automatic sensor_word_t gen_word();
    sensor_word_t w;
    int           f;
    int           b;
    int           r;
    int           pick;
    pick     = $urandom_range(0, 99);
    w.cmd    = $urandom_range(0, 1);
    w.finger = $urandom_range(0, 7);
    w.raw    = $urandom;
    w.base   = $urandom;
    w.full   = $urandom;
    if (pick < 12) return w;
    f = $urandom_range(0, NumFingers - 1);
    w.finger = f;
    if (pick < 30) begin
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8190) : $urandom_range(0, 1500);
      w.cmd  = CmdLoad;
      w.base = b;
      w.full = b + 1 + $urandom_range(0, (8190 - b < 3000) ? 8190 - b : 3000);
    end else begin
      b     = finger_base[f];
      w.cmd = CmdSample;
      case ($urandom_range(0, 3))
        0: r = b + int'(press_off) + int'($urandom_range(0, 300));
        1: r = b + int'(release_off) - int'($urandom_range(0, 300));
        2: r = b + int'(press_off) - int'($urandom_range(0, 40));
        default: r = $urandom_range(0, 4095);
      endcase
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      w.raw = r;
    end
    return w;
  endfunction

  task automatic send_word(sensor_word_t w);
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.command     = w.cmd;
    in_ch.finger      = w.finger;
    in_ch.raw         = w.raw;
    in_ch.baseline_in = w.base;
    in_ch.full_in     = w.full;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_event(w);
    words_sent++;
  endtask

  task automatic sender_gap(int n);
    if (n <= 0) return;
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic pace();
    if (!sender_bursty) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sender_gap($urandom_range(1, 12));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // sender holds off until all events are out, then lets loads settle
  task automatic wait_drain();
    sender_gap(1);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PRESS_OFFSET:   press_off   = data;
      CFG_RELEASE_OFFSET: release_off = data;
      CFG_HAND_ID:        hand_sel    = data[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // receiver: long hold first, else the current stall mode
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready = 1'b0;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ch.ready = 1'b1;
        RX_PATTERN: out_ch.ready = RxPattern[rx_phase % 16];
        RX_RANDOM:  out_ch.ready = ($urandom_range(0, 3) != 0);
        default:    out_ch.ready = ($urandom_range(0, 7) == 0);
      endcase
      rx_phase++;
    end
  end

  always @(posedge clk) begin
    press_event_t exp_ev;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: finger %0d kind %0d", out_ch.finger_out, out_ch.event_kind);
        errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (out_ch.hand !== exp_ev.hand) begin
          $error("hand: expected %0d, got %0d", exp_ev.hand, out_ch.hand);
          errors++;
        end
        if (out_ch.finger_out !== exp_ev.finger) begin
          $error("finger_out: expected %0d, got %0d", exp_ev.finger, out_ch.finger_out);
          errors++;
        end
        if (out_ch.event_kind !== exp_ev.kind) begin
          $error("event_kind: expected %0d, got %0d", exp_ev.kind, out_ch.event_kind);
          errors++;
        end
        if (out_ch.velocity !== exp_ev.velocity) begin
          $error("velocity: expected %0d, got %0d", exp_ev.velocity, out_ch.velocity);
          errors++;
        end
        events_seen++;
        if (exp_ev.kind == KindPress) presses_seen++;
      end
    end
  end

  // reset calibration: zero span, so any press gives full velocity
  task automatic test_reset_state();
    send_word(sample_word(0, 44));
    send_word(sample_word(0, 45));
    send_word(sample_word(0, 26));
    send_word(sample_word(0, 25));
    send_word(sample_word(5, 4095));
    send_word(sample_word(7, 4095));
    send_word(load_word(6, 0, 8191));
  endtask

  task automatic test_calibration();
    wait_drain();
    write_reg(CFG_HAND_ID, 1);
    write_reg(CFG_PRESS_OFFSET, 0);
    write_reg(CfgIdxSpare, '1);
    rx_mode = RX_PATTERN;
    send_word(load_word(1, 0, 8191));
    send_word(sample_word(1, 0));
    // bad loads: equal and inverted levels must leave finger 1 alone
    send_word(load_word(1, 100, 100));
    send_word(load_word(1, 200, 50));
    send_word(sample_word(1, 25));
    send_word(sample_word(1, 4095));
    send_word(load_word(2, 8190, 8191));
    send_word(sample_word(2, 4095));
    send_word(load_word(3, 100, 200));
    send_word(sample_word(3, 4095));
    send_word(load_word(4, 4000, 8191));
    send_word(sample_word(4, 4095));
  endtask

  task automatic test_offset_extremes();
    wait_drain();
    write_reg(CFG_PRESS_OFFSET, '1);
    write_reg(CFG_RELEASE_OFFSET, '1);
    write_reg(CFG_HAND_ID, 0);
    send_word(sample_word(4, 0));
    send_word(sample_word(0, 4094));
    send_word(sample_word(0, 4095));
    send_word(sample_word(0, 4095));
  endtask

  // receiver stops while every sample toggles finger 0, so the block backs up
  task automatic test_backpressure();
    int i;
    wait_drain();
    write_reg(CFG_PRESS_OFFSET, 45);
    write_reg(CFG_RELEASE_OFFSET, 25);
    rx_mode = RX_ALWAYS;
    send_word(load_word(0, 0, 1000));
    @(posedge clk);
    rx_hold_left = HoldCycles;
    for (i = 0; i < 24; i++) send_word(sample_word(0, (i % 2 == 0) ? 1000 : 0));
    wait_drain();
  endtask

  task automatic run_phase(logic [OffW-1:0] p_off, logic [OffW-1:0] r_off, logic hand,
                           rx_mode_e mode, bit bursty, int words);
    int           useful;
    sensor_word_t w;
    wait_drain();
    write_reg(CFG_PRESS_OFFSET, p_off);
    write_reg(CFG_RELEASE_OFFSET, r_off);
    write_reg(CFG_HAND_ID, hand);
    rx_mode       = mode;
    sender_bursty = bursty;
    burst_left    = 0;
    useful        = 0;
    while (useful < words) begin
      w = gen_word();
      send_word(w);
      pace();
      if (w.finger < NumFingers && !(w.cmd == CmdLoad && w.base >= w.full)) useful++;
    end
    random_words += useful;
  endtask

  task automatic test_random_phases();
    run_phase(45, 25, 0, RX_ALWAYS, 0, RandomWords / 4);
    run_phase(0, 0, 1, RX_PATTERN, 1, RandomWords / 4);
    run_phase($urandom_range(0, 300), $urandom_range(0, 400), 0, RX_RANDOM, 1,
              RandomWords / 4);
    run_phase($urandom_range(0, 200), $urandom_range(0, 200), 1, RX_SLOW, 1,
              RandomWords / 4);
  endtask

  initial begin
    #TimeoutUnits;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CmdSample;
    in_ch.finger      = '0;
    in_ch.raw         = '0;
    in_ch.baseline_in = '0;
    in_ch.full_in     = '0;
    out_ch.ready      = 1'b0;
    rx_mode           = RX_ALWAYS;
    rx_hold_left      = 0;
    rx_phase          = 0;
    burst_left        = 0;
    sender_bursty     = 1'b0;
    errors            = 0;
    words_sent        = 0;
    random_words      = 0;
    events_seen       = 0;
    presses_seen      = 0;
    cfg_writes        = 0;
    press_off         = PressOffRst;
    release_off       = ReleaseOffRst;
    hand_sel          = 1'b0;
    for (int f = 0; f < NumFingers; f++) begin
      finger_pressed[f] = 1'b0;
      finger_base[f]    = '0;
      finger_full[f]    = '0;
    end
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_calibration();
    test_offset_extremes();
    test_backpressure();
    test_random_phases();
    wait_drain();

    $display("Sent %0d words (%0d random, not counting ignored), %0d register writes",
             words_sent, random_words, cfg_writes);
    $display("Checked %0d events: %0d presses, %0d releases",
             events_seen, presses_seen, events_seen - presses_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* pressure_press_detect_velocity.f */
design/ppdv_pkg.sv
design/ppdv_in_if.sv
design/ppdv_out_if.sv
design/ppdv_ctrl.sv
design/ppdv_dp.sv
design/pressure_press_detect_velocity.sv
tb/pressure_press_detect_velocity_tb.sv
